// ===== rtl/wfp_pkg.sv =====
package wfp_pkg;

  localparam int CHUNK_LEN   = 5;
  localparam int WINDOW_LEN  = 4;
  localparam int INDEX_BITS  = 24;

  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 7;
  localparam int INDEX_OUT_W = 24;
  localparam int HASH_MOD    = 99;
  localparam int LOWER_FIRST = 97;
  localparam int LOWER_LAST  = 122;
  localparam int CASE_OFFSET = 32;

  localparam int CNT_W    = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
  localparam int RECENT_N = (WINDOW_LEN > 1) ? WINDOW_LEN - 1 : 1;
  localparam int BEST_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam int OUT_TDATA_W = ((HASH_W + INDEX_OUT_W + 7) / 8) * 8;
  localparam int SUM_W       = BYTE_W + 2;

  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  typedef struct packed {
    logic                   emit;
    hash_t                  hash;
    logic [INDEX_OUT_W-1:0] index;
    logic                   wrapped;
  } wfp_res_t;

  // Residue of (a + b) modulo the hash modulus, where a is already reduced.
  function automatic hash_t mod_add(hash_t a, byte_t b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(3 * HASH_MOD)) begin
      s = s - SUM_W'(3 * HASH_MOD);
    end else if (s >= SUM_W'(2 * HASH_MOD)) begin
      s = s - SUM_W'(2 * HASH_MOD);
    end else if (s >= SUM_W'(HASH_MOD)) begin
      s = s - SUM_W'(HASH_MOD);
    end
    return s[HASH_W-1:0];
  endfunction

  // Folds lowercase ASCII letters to uppercase.
  function automatic byte_t fold_case(byte_t b);
    byte_t r;
    r = b;
    if (b >= BYTE_W'(LOWER_FIRST) && b <= BYTE_W'(LOWER_LAST)) begin
      r = b - BYTE_W'(CASE_OFFSET);
    end
    return r;
  endfunction

endpackage

// ===== rtl/wfp_core.sv =====
module wfp_core
  import wfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  byte_t    text_byte_i,
  input  logic     doc_start_i,
  output wfp_res_t res_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  hash_t             sum_q, sum_d;
  hash_t             rec_q [RECENT_N];
  hash_t             rec_d [RECENT_N];
  index_t            chunks_q, chunks_d;
  index_t            last_q, last_d;
  logic              any_q, any_d;
  logic              wrap_q, wrap_d;

  logic [CNT_W-1:0]  cur_cnt;
  hash_t             cur_sum;
  hash_t             cur_rec [RECENT_N];
  index_t            cur_chunks;
  index_t            cur_last;
  logic              cur_any;
  logic              cur_wrap;

  hash_t             sum_n;
  hash_t             win [WINDOW_LEN];
  logic [BEST_W-1:0] best;
  logic              done;
  logic              full;
  index_t            sel;
  logic [31:0]       sel_ext;
  logic              emit;

  always_comb begin
    cur_cnt    = doc_start_i ? '0 : cnt_q;
    cur_sum    = doc_start_i ? '0 : sum_q;
    cur_chunks = doc_start_i ? '0 : chunks_q;
    cur_last   = doc_start_i ? '0 : last_q;
    cur_any    = doc_start_i ? 1'b0 : any_q;
    cur_wrap   = doc_start_i ? 1'b0 : wrap_q;
    for (int k = 0; k < RECENT_N; k++) begin
      cur_rec[k] = doc_start_i ? '0 : rec_q[k];
    end

    sum_n = mod_add(cur_sum, fold_case(text_byte_i));
    done  = (cur_cnt == CNT_W'(CHUNK_LEN - 1));

    for (int k = 0; k < WINDOW_LEN - 1; k++) begin
      win[k] = cur_rec[k];
    end
    win[WINDOW_LEN-1] = sum_n;

    // Minimum over the window; the newest chunk wins a tie.
    best = '0;
    for (int k = 1; k < WINDOW_LEN; k++) begin
      if (win[best] >= win[k]) begin
        best = BEST_W'(k);
      end
    end

    full    = cur_wrap || (cur_chunks >= INDEX_BITS'(WINDOW_LEN - 1));
    sel     = cur_chunks - (INDEX_BITS'(WINDOW_LEN - 1) - INDEX_BITS'(best));
    sel_ext = 32'(sel);
    emit    = done && full && (!cur_any || (sel != cur_last));

    res_o.emit    = emit;
    res_o.hash    = win[best];
    res_o.index   = sel_ext[INDEX_OUT_W-1:0];
    res_o.wrapped = cur_wrap;

    cnt_d    = done ? '0 : cur_cnt + CNT_W'(1);
    sum_d    = done ? '0 : sum_n;
    chunks_d = done ? cur_chunks + INDEX_BITS'(1) : cur_chunks;
    wrap_d   = cur_wrap || (done && (chunks_d == '0));
    any_d    = cur_any || emit;
    last_d   = emit ? sel : cur_last;
    for (int k = 0; k < RECENT_N; k++) begin
      rec_d[k] = cur_rec[k];
    end
    if (done && (WINDOW_LEN > 1)) begin
      for (int k = 0; k < RECENT_N - 1; k++) begin
        rec_d[k] = cur_rec[k+1];
      end
      rec_d[RECENT_N-1] = sum_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      chunks_q <= '0;
      last_q   <= '0;
      any_q    <= 1'b0;
      wrap_q   <= 1'b0;
      for (int k = 0; k < RECENT_N; k++) begin
        rec_q[k] <= '0;
      end
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      chunks_q <= chunks_d;
      last_q   <= last_d;
      any_q    <= any_d;
      wrap_q   <= wrap_d;
      for (int k = 0; k < RECENT_N; k++) begin
        rec_q[k] <= rec_d[k];
      end
    end
  end

endmodule

// ===== rtl/winnowing_fingerprint_top.sv =====
// Winnowing fingerprint of a text stream.
// The slave channel takes one text byte per item in s_axis_tdata; s_axis_tuser
// marks the first byte of a new document and clears all running state first.
// Bytes are gathered into chunks of five, lowercase letters folded to
// uppercase, and each chunk hashed as its byte sum modulo 99. Over the last
// four chunk hashes the minimum is picked, the newest on a tie, and an item
// goes out on the master channel whenever the chosen chunk index changes.
// The master item carries the hash and chunk index in m_axis_tdata and the
// counter wrap flag in m_axis_tuser.
// An accepted byte is registered and processed once the core may advance; its
// result, if any, is loaded into the output register as the byte advances and
// is shown on the master side until the receiver takes it. One byte is taken
// every cycle unless a result waits on a stalled receiver; the per-chunk sum
// is kept as a running residue, so the hash, window compare and state update
// are combinational.
// When the receiver stalls, a waiting result is held in the output register;
// bytes that produce no result keep flowing, and the slave side stops only
// when a result-producing byte finds the output register still occupied.
// Reset clears all document state and the valid flags of both pipeline registers.
module winnowing_fingerprint_top
  import wfp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tuser,   // [0] doc_start
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [6:0] print_hash, [30:7] chunk_index
  output logic                   m_axis_tuser    // [0] index_wrapped
);

  logic     in_valid_q;
  byte_t    in_byte_q;
  logic     in_start_q;
  logic     out_valid_q;
  wfp_res_t out_q;
  wfp_res_t res;
  logic     out_free;
  logic     advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (out_free || !res.emit);
  assign s_axis_tready = !in_valid_q || advance;

  wfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .text_byte_i (in_byte_q),
    .doc_start_i (in_start_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.index, out_q.hash});
  assign m_axis_tuser  = out_q.wrapped;

  a_hash_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[HASH_W-1:0] < HASH_W'(HASH_MOD)))
    else $error("output hash out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_valid_q))
    else $error("result appeared without a registered input item");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

endmodule
